>>> rtl/psadpcm_pkg.sv
// Types, constants and the predictor filter table of the PS-ADPCM nibble decoder.
package psadpcm_pkg;

  localparam int unsigned CodeW   = 4;
  localparam int unsigned FilterW = 4;
  localparam int unsigned ShiftW  = 4;
  localparam int unsigned FlagsW  = 8;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW   = 8;
  localparam int unsigned ProdW   = CoefW + SampleW;
  localparam int unsigned SumW    = 28;
  localparam int unsigned ScaledW = SumW - 8;

  localparam logic [4:0]        ShiftBase  = 5'd20;
  localparam logic [FlagsW-1:0] FlagLimit  = 8'h07;
  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7fff;
  localparam logic signed [SampleW-1:0] SampleMin = -16'sh8000;

  typedef enum logic [FilterW-1:0] {
    FILT_NONE  = 4'd0,
    FILT_ONE   = 4'd1,
    FILT_TWO   = 4'd2,
    FILT_THREE = 4'd3,
    FILT_FOUR  = 4'd4
  } filter_e;

  typedef struct packed {
    logic signed [CoefW-1:0] k1;
    logic signed [CoefW-1:0] k2;
  } coef_pair_t;

  // Filter pairs in 64ths; unknown selectors give no prediction.
  function automatic coef_pair_t filter_coefs(input logic [FilterW-1:0] sel);
    coef_pair_t c;
    c.k1 = 8'sd0;
    c.k2 = 8'sd0;
    unique case (sel)
      FILT_ONE: begin
        c.k1 = 8'sd60;
      end
      FILT_TWO: begin
        c.k1 = 8'sd115;
        c.k2 = -8'sd52;
      end
      FILT_THREE: begin
        c.k1 = 8'sd98;
        c.k2 = -8'sd55;
      end
      FILT_FOUR: begin
        c.k1 = 8'sd122;
        c.k2 = -8'sd60;
      end
      default: begin
        c.k1 = 8'sd0;
        c.k2 = 8'sd0;
      end
    endcase
    return c;
  endfunction

endpackage

>>> rtl/ps_adpcm_nibble_decoder_core.sv
// Top level of the PS-ADPCM nibble decoder: input register, predictor and result register.

// Decodes one 4-bit PS-ADPCM code per request into a signed 16-bit PCM sample, with a
// flag that marks saturation. A request is held in an input register, the prediction from
// the two previous samples is formed in one pass of logic and the sample is written to the
// result register, so the decoder takes one request every clock cycle while the output side
// does not stall. The history registers are updated in the same edge that loads the result
// register, so each request sees the samples of all earlier ones. The input side stalls only
// while both registers are full and the output side stalls. A frame flags byte at or above
// the limit gives a zero sample.
module ps_adpcm_nibble_decoder_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [psadpcm_pkg::CodeW-1:0]        code_nibble_i,
  input  logic [psadpcm_pkg::FilterW-1:0]      filter_index_i,
  input  logic [psadpcm_pkg::ShiftW-1:0]       shift_amount_i,
  input  logic [psadpcm_pkg::FlagsW-1:0]       frame_flags_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [psadpcm_pkg::SampleW-1:0] pcm_sample_o,
  output logic                                 clipped_o
);
  import psadpcm_pkg::*;

  logic                      in_valid_q;
  logic [CodeW-1:0]          code_q;
  logic [FilterW-1:0]        filter_q;
  logic [ShiftW-1:0]         shift_q;
  logic [FlagsW-1:0]         flags_q;
  logic                      out_valid_q;
  logic signed [SampleW-1:0] sample_q, sample_d;
  logic                      clipped_q, clipped_d;
  logic signed [SampleW-1:0] hist_one_q, hist_two_q;

  logic                      out_free;
  logic                      advance;
  logic                      load_in;
  coef_pair_t                coefs;
  logic signed [SumW-1:0]    code_term;
  logic signed [ProdW-1:0]   prod_one, prod_two;
  logic signed [SumW-1:0]    sum;
  logic signed [ScaledW-1:0] scaled;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign load_in    = !in_valid_q || out_free;
  assign in_stall_o = !load_in;

  always_comb begin
    coefs     = filter_coefs(filter_q);
    code_term = SumW'(signed'(code_q)) <<< (ShiftBase - {1'b0, shift_q});
    prod_one  = ProdW'(coefs.k1) * ProdW'(hist_one_q);
    prod_two  = ProdW'(coefs.k2) * ProdW'(hist_two_q);
    sum       = code_term + ((SumW'(prod_one) + SumW'(prod_two)) <<< 2);
    scaled    = ScaledW'(sum >>> 8);
    sample_d  = '0;
    clipped_d = 1'b0;
    if (flags_q < FlagLimit) begin
      priority if (scaled > ScaledW'(SampleMax)) begin
        sample_d  = SampleMax;
        clipped_d = 1'b1;
      end else if (scaled < ScaledW'(SampleMin)) begin
        sample_d  = SampleMin;
        clipped_d = 1'b1;
      end else begin
        sample_d  = SampleW'(scaled);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hist_one_q  <= '0;
      hist_two_q  <= '0;
    end else begin
      if (load_in) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        hist_one_q <= sample_d;
        hist_two_q <= hist_one_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in && in_valid_i) begin
      code_q   <= code_nibble_i;
      filter_q <= filter_index_i;
      shift_q  <= shift_amount_i;
      flags_q  <= frame_flags_i;
    end
    if (advance) begin
      sample_q  <= sample_d;
      clipped_q <= clipped_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pcm_sample_o = sample_q;
  assign clipped_o    = clipped_q;

endmodule

>>> rtl/psadpcm_checker.sv
// Port-level assertions of the PS-ADPCM nibble decoder and their binding to the top level.
module psadpcm_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic signed [psadpcm_pkg::SampleW-1:0] pcm_sample_o,
  input logic                                   clipped_o
);
  import psadpcm_pkg::*;

  // A saturated sample sits at one of the two limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |-> (pcm_sample_o == SampleMax || pcm_sample_o == SampleMin))
    else $error("clipped sample is not at a limit");

  // The input side stalls only while a finished sample is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(pcm_sample_o) && $stable(clipped_o)))
    else $error("stalled result changed");

  // With the output side free, an accepted request passes through the input and result registers to a valid sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_stall_i) ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted request gave no sample");

endmodule

bind ps_adpcm_nibble_decoder_core psadpcm_checker u_psadpcm_checker (.*);

>>> dv/tb_top.sv
// Self-checking testbench for the PS-ADPCM nibble decoder core.
`timescale 1ns / 100ps

module tb_top;
  import psadpcm_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 1550;
  localparam int unsigned FrameLen = 28;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic signed [SampleW-1:0] pcm;
    logic clipped;
  } decoded_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall_o;
  logic [CodeW-1:0] code_nibble;
  logic [FilterW-1:0] filter_index;
  logic [ShiftW-1:0] shift_amount;
  logic [FlagsW-1:0] frame_flags;
  logic out_valid_o;
  logic out_stall;
  logic signed [SampleW-1:0] pcm_sample_o;
  logic clipped_o;

  decoded_t pending_samples[$];
  decoded_t oldest_sample;
  int hist_recent;
  int hist_older;
  int errors;
  int items_sent;
  int samples_checked;
  int clip_count;
  int silenced_count;
  int frames_sent;
  int burst_left;
  bit sender_idle;
  bit stall_enable;
  stall_mode_e stall_mode;
  int unsigned stall_tick;

  ps_adpcm_nibble_decoder_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .code_nibble_i  (code_nibble),
    .filter_index_i (filter_index),
    .shift_amount_i (shift_amount),
    .frame_flags_i  (frame_flags),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .pcm_sample_o   (pcm_sample_o),
    .clipped_o      (clipped_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic decoded_t predict_sample(input logic [CodeW-1:0] code,
                                              input logic [FilterW-1:0] filt,
                                              input logic [ShiftW-1:0] shift,
                                              input logic [FlagsW-1:0] flags);
    decoded_t d;
    int k1;
    int k2;
    int c;
    int sh;
    int acc;
    d.pcm = '0;
    d.clipped = 1'b0;
    k1 = 0;
    k2 = 0;
    if (flags < FlagLimit) begin
      case (filt)
        FILT_ONE: begin
          k1 = 60;
        end
        FILT_TWO: begin
          k1 = 115;
          k2 = -52;
        end
        FILT_THREE: begin
          k1 = 98;
          k2 = -55;
        end
        FILT_FOUR: begin
          k1 = 122;
          k2 = -60;
        end
        default: begin
          k1 = 0;
          k2 = 0;
        end
      endcase
      c = $signed(code);
      sh = ShiftBase - shift;
      acc = c * (1 << sh) + 4 * (k1 * hist_recent + k2 * hist_older);
      acc = acc >>> 8;
      if (acc > SampleMax) begin
        d.pcm = SampleMax;
        d.clipped = 1'b1;
      end else if (acc < SampleMin) begin
        d.pcm = SampleMin;
        d.clipped = 1'b1;
      end else begin
        d.pcm = acc[SampleW-1:0];
      end
    end else begin
      silenced_count++;
    end
    if (d.clipped) begin
      clip_count++;
    end
    hist_older = hist_recent;
    hist_recent = $signed(d.pcm);
    return d;
  endfunction

  task automatic send_code(input logic [CodeW-1:0] code, input logic [FilterW-1:0] filt,
                           input logic [ShiftW-1:0] shift, input logic [FlagsW-1:0] flags);
    int gap;
    decoded_t expected;
    if (sender_idle && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    code_nibble <= code;
    filter_index <= filt;
    shift_amount <= shift;
    frame_flags <= flags;
    do @(posedge clk_i); while (in_stall_o);
    expected = predict_sample(code, filt, shift, flags);
    pending_samples.insert(pending_samples.size(), expected);
    if (burst_left > 0) begin
      burst_left--;
    end
    items_sent++;
  endtask

  task automatic send_random_frame();
    logic [FilterW-1:0] filt;
    logic [ShiftW-1:0] shift;
    logic [FlagsW-1:0] flags;
    if ($urandom_range(0, 9) < 8) begin
      filt = FilterW'($urandom_range(FILT_NONE, FILT_FOUR));
    end else begin
      filt = FilterW'($urandom_range(5, 15));
    end
    shift = ($urandom_range(0, 4) == 0) ? ShiftW'($urandom_range(0, 15))
                                        : ShiftW'($urandom_range(0, 12));
    flags = ($urandom_range(0, 9) < 8) ? FlagsW'($urandom_range(0, 6))
                                       : FlagsW'($urandom_range(7, 255));
    for (int i = 0; i < FrameLen; i++) begin
      send_code(CodeW'($urandom_range(0, 15)), filt, shift, flags);
    end
    frames_sent++;
  endtask

  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_code(CodeW'($urandom_range(0, 15)), FilterW'($urandom_range(0, 15)),
                ShiftW'($urandom_range(0, 15)), FlagsW'($urandom_range(0, 255)));
    end
  endtask

  // Full-scale codes at shift zero drive the predictor into both rails, then small codes at large shifts.
  task automatic test_extremes();
    send_code(4'h7, FILT_NONE, 4'd0, 8'd0);
    send_code(4'h7, FILT_FOUR, 4'd0, 8'd0);
    send_code(4'h7, FILT_TWO, 4'd0, 8'd0);
    send_code(4'h8, FILT_NONE, 4'd0, 8'd0);
    send_code(4'h8, FILT_FOUR, 4'd0, 8'd0);
    send_code(4'h8, FILT_THREE, 4'd0, 8'd0);
    send_code(4'hF, FILT_NONE, 4'd15, 8'd0);
    send_code(4'h1, FILT_NONE, 4'd15, 8'd0);
    send_code(4'h3, FILT_ONE, 4'd12, 8'd0);
    send_code(4'hC, FILT_THREE, 4'd13, 8'd0);
  endtask

  // Flag bytes at and beyond the limit silence the sample but still shift the history.
  task automatic test_frame_flags();
    send_code(4'h7, FILT_NONE, 4'd4, 8'd6);
    send_code(4'h7, FILT_ONE, 4'd4, FlagLimit);
    send_code(4'h5, FILT_FOUR, 4'd2, 8'hFF);
    send_code(4'h9, FILT_TWO, 4'd3, 8'h80);
    send_code(4'h4, FILT_FOUR, 4'd1, 8'd1);
  endtask

  // Unknown filter selectors must give no prediction from a non-zero history.
  task automatic test_unknown_filters();
    send_code(4'h6, FILT_NONE, 4'd2, 8'd0);
    send_code(4'h0, 4'd5, 4'd0, 8'd0);
    send_code(4'h5, FILT_ONE, 4'd1, 8'd0);
    send_code(4'h0, 4'd15, 4'd0, 8'd0);
    send_code(4'h2, 4'd10, 4'd9, 8'd0);
  endtask

  task automatic test_back_to_back();
    sender_idle = 1'b0;
    stall_enable = 1'b0;
    repeat (5) send_random_frame();
    sender_idle = 1'b1;
    stall_enable = 1'b1;
  endtask

  task automatic test_random_stream();
    int target;
    target = items_sent + RandomItems;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise($urandom_range(1, 12));
      end else begin
        send_random_frame();
      end
    end
  endtask

  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick[7:0] == 8'd0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
    end
    if (!stall_enable) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
        STALL_PERIODIC: out_stall <= (stall_tick[3:2] == 2'b11);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $error("sample %0d arrived with none expected", pcm_sample_o);
        errors++;
      end else begin
        oldest_sample = pending_samples.pop_front();
        if (pcm_sample_o !== oldest_sample.pcm) begin
          $error("pcm_sample: expected %0d, got %0d", oldest_sample.pcm, pcm_sample_o);
          errors++;
        end
        if (clipped_o !== oldest_sample.clipped) begin
          $error("clipped: expected %0b, got %0b", oldest_sample.clipped, clipped_o);
          errors++;
        end
        samples_checked++;
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    errors = 0;
    items_sent = 0;
    samples_checked = 0;
    clip_count = 0;
    silenced_count = 0;
    frames_sent = 0;
    burst_left = 0;
    hist_recent = 0;
    hist_older = 0;
    sender_idle = 1'b1;
    stall_enable = 1'b1;
    stall_mode <= STALL_NONE;
    stall_tick <= 0;
    rst_ni <= 1'b0;
    in_valid <= 1'b0;
    code_nibble <= '0;
    filter_index <= '0;
    shift_amount <= '0;
    frame_flags <= '0;
    out_stall <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_frame_flags();
    test_unknown_filters();
    test_back_to_back();
    test_random_stream();

    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d codes in %0d random frames plus directed and noise items.",
             items_sent, frames_sent);
    $display("Checked %0d samples: %0d saturated, %0d silenced by the frame flags.",
             samples_checked, clip_count, silenced_count);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> ps_adpcm_nibble_decoder_core.f
rtl/psadpcm_pkg.sv
rtl/ps_adpcm_nibble_decoder_core.sv
rtl/psadpcm_checker.sv
dv/tb_top.sv
